/* rtl/core/akt_pkg.sv */
// ----------------------------------------------------------------------------
// akt_pkg
// Shared types and codes for the authentication key table: command codes,
// status codes, flag bits and the slot entry layout.
// ----------------------------------------------------------------------------
package akt_pkg;

  // Command codes carried in the low bits of the input word
  typedef enum logic [2:0] {
    CMD_WRITE      = 3'd0,
    CMD_TRUST      = 3'd1,
    CMD_UNTRUST    = 3'd2,
    CMD_DELETE     = 3'd3,
    CMD_HAVE_KEY   = 3'd4,
    CMD_IS_TRUSTED = 3'd5,
    CMD_READ       = 3'd6,
    CMD_NOP        = 3'd7
  } cmd_t;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Entry flag bits
  localparam logic [2:0] FLAG_TRUSTED = 3'b001;
  localparam logic [2:0] FLAG_KNOWN   = 3'b010;
  localparam logic [2:0] FLAG_MD5     = 3'b100;

  // Widest key-word mask (word index is two bits)
  localparam int WMASK_W = 4;

  // One slot of the key table; wmask marks key words written since allocation
  typedef struct packed {
    logic               valid;
    logic [31:0]        keyid;
    logic [2:0]         flags;
    logic [5:0]         length;
    logic [WMASK_W-1:0] wmask;
  } slot_entry_t;

  // Search request from the command sequencer
  typedef struct packed {
    logic        start;
    logic [31:0] id;
  } scan_req_t;

  // Slot write from the command sequencer
  typedef struct packed {
    logic        en;
    slot_entry_t entry;
  } slot_wr_t;

  // Search result back to the command sequencer
  typedef struct packed {
    logic        done;
    logic        hit;
    logic        free_ok;
    slot_entry_t entry;
  } scan_res_t;

endpackage

/* rtl/core/auth_key_table_with_cache.sv */
// ----------------------------------------------------------------------------
// auth_key_table_with_cache
// Authentication key table searched by 32-bit key id, with a one-entry
// lookup cache for have-key / is-trusted queries.
// ----------------------------------------------------------------------------
// One command at a time: each word is searched and executed before the next is
// accepted, and a read key word that hits a written word also reads the key
// store; the search reads the slot memory one slot per cycle. After reset the
// slot memory is cleared in a pass over every slot, during which in_tready
// stays low. A finished result sits in the output register while the next
// word is taken and searched. Exactly one result word per input word.
module auth_key_table_with_cache
  import akt_pkg::*;
#(
  parameter int NUM_SLOTS = 64,
  parameter int KEY_WORDS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  // cmd[2:0], key_id[34:3], key_data[98:35], word_index[100:99],
  // key_length[106:101], zero pad[111:107]
  input  logic [111:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // status[1:0], answer[2], is_trusted[3], is_known[4], stored_length[10:5],
  // read_word[74:11], entries_used[81:75], zero pad[87:82]
  output logic [87:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready
);

  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int KA_W      = IDX_W + 2;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int LEN_CAP_I = (KEY_WORDS * 8 < 32) ? KEY_WORDS * 8 : 32;
  localparam logic [5:0] LEN_CAP = 6'(LEN_CAP_I);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_KRD, S_OUT} state_t;

  state_t           state_r;
  cmd_t             cmd_r;
  logic [31:0]      id_r;
  logic [63:0]      data_r;
  logic [1:0]       widx_r;
  logic [5:0]       klen_r;
  logic [31:0]      cached_id_r;
  logic             cached_tr_r;
  logic [CNT_W-1:0] used_cnt_r;
  logic [1:0]       res_status_r;
  logic             res_answer_r;
  logic             res_trusted_r;
  logic             res_known_r;
  logic [5:0]       res_len_r;
  logic [63:0]      res_word_r;
  logic             out_valid_r;
  logic [87:0]      out_data_r;

  logic             in_acc;
  logic             tbl_ready;
  scan_req_t        sreq;
  scan_res_t        sres;
  slot_wr_t         swr;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  logic [63:0]      key_rdata;

  // command decode outputs
  slot_entry_t      new_ent;
  slot_entry_t      blank_ent;
  logic [IDX_W-1:0] tgt;
  logic             sw_en;
  logic             kw_en;
  logic             kr_en;
  logic             out_has;
  logic [1:0]       st_nxt;
  logic             ans_nxt;
  logic             flush;
  logic             load;
  logic             inc;
  logic             dec;
  logic             widx_ok;
  logic [5:0]       len_sat;
  logic             exec;
  logic [31:0]      cached_id_nxt;
  logic             cached_tr_nxt;
  logic [CNT_W-1:0] used_cnt_nxt;

  assign in_tready = (state_r == S_IDLE) && tbl_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign exec      = (state_r == S_EXEC);

  // Search request straight from the accepted word
  assign sreq.start = in_acc;
  assign sreq.id    = in_tdata[34:3];

  akt_slot_table #(
    .NUM_SLOTS(NUM_SLOTS),
    .IDX_W    (IDX_W)
  ) u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sreq),
    .wr      (swr),
    .wr_addr (tgt),
    .ready   (tbl_ready),
    .res     (sres),
    .hit_idx (hit_idx),
    .free_idx(free_idx)
  );

  akt_key_store #(
    .NUM_SLOTS(NUM_SLOTS),
    .KA_W     (KA_W)
  ) u_keys (
    .clk  (clk),
    .we   (exec && kw_en),
    .re   (exec && kr_en),
    .addr ({tgt, widx_r}),
    .wdata(data_r),
    .rdata(key_rdata)
  );

  // Command decode on the search result
  always_comb begin
    widx_ok   = (4'(widx_r) < 4'(KEY_WORDS));
    len_sat   = (klen_r > LEN_CAP) ? LEN_CAP : klen_r;
    blank_ent = '{valid: 1'b1, keyid: id_r, flags: '0, length: '0, wmask: '0};
    new_ent   = sres.entry;
    tgt       = hit_idx;
    sw_en     = 1'b0;
    kw_en     = 1'b0;
    kr_en     = 1'b0;
    out_has   = 1'b0;
    st_nxt    = ST_OK;
    ans_nxt   = 1'b0;
    flush     = 1'b0;
    load      = 1'b0;
    inc       = 1'b0;
    dec       = 1'b0;
    unique case (cmd_r)
      CMD_WRITE: begin
        if (!sres.hit && !sres.free_ok) begin
          st_nxt = ST_FULL;
        end else begin
          if (!sres.hit) begin
            new_ent = blank_ent;
            tgt     = free_idx;
            inc     = 1'b1;
          end
          new_ent.flags  = new_ent.flags | FLAG_KNOWN | FLAG_MD5;
          new_ent.length = len_sat;
          if (widx_ok) begin
            new_ent.wmask[widx_r] = 1'b1;
          end
          kw_en   = widx_ok;
          sw_en   = 1'b1;
          flush   = 1'b1;
          out_has = 1'b1;
        end
      end
      CMD_TRUST: begin
        if (!sres.hit && !sres.free_ok) begin
          st_nxt = ST_FULL;
        end else begin
          if (!sres.hit) begin
            new_ent = blank_ent;
            tgt     = free_idx;
            inc     = 1'b1;
          end
          new_ent.flags = new_ent.flags | FLAG_TRUSTED;
          sw_en   = 1'b1;
          flush   = 1'b1;
          out_has = 1'b1;
        end
      end
      CMD_UNTRUST: begin
        if (!sres.hit) begin
          st_nxt = ST_NOT_FOUND;
        end else begin
          new_ent.flags = new_ent.flags & ~FLAG_TRUSTED;
          // an entry that was only trusted goes away
          if ((new_ent.flags & FLAG_KNOWN) == '0) begin
            new_ent.valid = 1'b0;
            dec           = 1'b1;
          end else begin
            out_has = 1'b1;
          end
          sw_en = 1'b1;
          flush = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (!sres.hit) begin
          st_nxt = ST_NOT_FOUND;
        end else begin
          new_ent.valid = 1'b0;
          sw_en = 1'b1;
          dec   = 1'b1;
          flush = 1'b1;
        end
      end
      CMD_HAVE_KEY: begin
        out_has = sres.hit;
        if ((id_r == '0) || (id_r == cached_id_r)) begin
          ans_nxt = 1'b1;
        end else if (!sres.hit) begin
          st_nxt = ST_NOT_FOUND;
        end else if ((sres.entry.flags & FLAG_KNOWN) != '0) begin
          load    = 1'b1;
          ans_nxt = ((sres.entry.flags & FLAG_MD5) != '0);
        end
      end
      CMD_IS_TRUSTED: begin
        out_has = sres.hit;
        if (id_r == cached_id_r) begin
          ans_nxt = cached_tr_r;
        end else if (!sres.hit) begin
          st_nxt = ST_NOT_FOUND;
        end else begin
          ans_nxt = ((sres.entry.flags & FLAG_TRUSTED) != '0);
        end
      end
      CMD_READ: begin
        out_has = sres.hit;
        if (!sres.hit) begin
          st_nxt = ST_NOT_FOUND;
        end else begin
          // unwritten words read as zero without touching the store
          kr_en = widx_ok && sres.entry.wmask[widx_r];
        end
      end
      CMD_NOP: begin
        out_has = 1'b0;
      end
      default: begin
        out_has = 1'b0;
      end
    endcase

    swr.en    = exec && sw_en;
    swr.entry = new_ent;
  end

  // Cache and fill count updates
  always_comb begin
    cached_id_nxt = cached_id_r;
    cached_tr_nxt = cached_tr_r;
    used_cnt_nxt  = used_cnt_r;
    if (exec) begin
      if (flush && (cached_id_r == id_r)) begin
        cached_id_nxt = '0;
        cached_tr_nxt = 1'b0;
      end
      if (load) begin
        cached_id_nxt = id_r;
        cached_tr_nxt = ((sres.entry.flags & FLAG_TRUSTED) != '0);
      end
      if (inc) begin
        used_cnt_nxt = used_cnt_r + CNT_W'(1);
      end else if (dec) begin
        used_cnt_nxt = used_cnt_r - CNT_W'(1);
      end
    end
  end

  // Command sequencer, cache, count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cached_id_r <= '0;
      cached_tr_r <= 1'b0;
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cached_id_r <= cached_id_nxt;
      cached_tr_r <= cached_tr_nxt;
      used_cnt_r  <= used_cnt_nxt;
      // output word taken; in S_OUT the reload below keeps it valid
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r   <= cmd_t'(in_tdata[2:0]);
            id_r    <= in_tdata[34:3];
            data_r  <= in_tdata[98:35];
            widx_r  <= in_tdata[100:99];
            klen_r  <= in_tdata[106:101];
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sres.done) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status_r  <= st_nxt;
          res_answer_r  <= ans_nxt;
          res_trusted_r <= out_has && ((new_ent.flags & FLAG_TRUSTED) != '0);
          res_known_r   <= out_has && ((new_ent.flags & FLAG_KNOWN) != '0);
          res_len_r     <= out_has ? new_ent.length : '0;
          res_word_r    <= '0;
          state_r       <= kr_en ? S_KRD : S_OUT;
        end
        S_KRD: begin
          res_word_r <= key_rdata;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {6'd0, 7'(used_cnt_r), res_word_r, res_len_r,
                            res_known_r, res_trusted_r, res_answer_r,
                            res_status_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  // one word in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second word accepted while a command is in flight");

  // an empty cache never claims a trusted key
  a_cache_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (cached_id_r == '0) |-> !cached_tr_r)
    else $error("cache holds trusted bit for id zero");

  // fill count bounded by the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(used_cnt_r) <= NUM_SLOTS)
    else $error("entry count exceeds table size");

  // the search result arrives only while the sequencer waits for it
  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    sres.done |-> (state_r == S_SCAN))
    else $error("search completed outside a search");
`endif

endmodule

/* rtl/core/akt_slot_table.sv */
// ----------------------------------------------------------------------------
// akt_slot_table
// Slot memory with its clearing pass after reset and a sequential search
// that finds the lowest valid slot holding an id and the lowest free slot.
// ----------------------------------------------------------------------------
module akt_slot_table
  import akt_pkg::*;
#(
  parameter int NUM_SLOTS = 64,
  parameter int IDX_W     = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scan_req_t        req,
  input  slot_wr_t         wr,
  input  logic [IDX_W-1:0] wr_addr,
  output logic             ready,
  output scan_res_t        res,
  output logic [IDX_W-1:0] hit_idx,
  output logic [IDX_W-1:0] free_idx
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {T_CLR, T_IDLE, T_RUN} tstate_t;

  tstate_t          st_r;
  logic [IDX_W-1:0] ptr_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_v_r;
  logic             done_r;
  logic             hit_r;
  logic             free_r;
  logic [31:0]      id_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [IDX_W-1:0] free_idx_r;
  slot_entry_t      ent_r;

  slot_entry_t      mem [NUM_SLOTS];
  slot_entry_t      rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  slot_entry_t      mem_wd;
  logic             match;
  logic             is_free;

  // Write mux: clearing pass owns the port after reset
  always_comb begin
    mem_we = (st_r == T_CLR) || wr.en;
    mem_wa = (st_r == T_CLR) ? ptr_r : wr_addr;
    mem_wd = (st_r == T_CLR) ? '0 : wr.entry;
  end

  // Slot memory, one read and one write a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (st_r == T_RUN) begin
      rd_q <= mem[ptr_r];
    end
  end

  // Compare on the returning read
  always_comb begin
    match   = rd_q.valid && (rd_q.keyid == id_r);
    is_free = !rd_q.valid;
  end

  // Sequencer: clear pass, then one slot read per cycle per search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= T_CLR;
      ptr_r  <= '0;
      rd_v_r <= 1'b0;
      done_r <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else begin
      rd_v_r   <= (st_r == T_RUN);
      rd_idx_r <= ptr_r;
      done_r   <= rd_v_r && (rd_idx_r == LAST);
      unique case (st_r)
        T_CLR: begin
          if (ptr_r == LAST) begin
            st_r  <= T_IDLE;
            ptr_r <= '0;
          end else begin
            ptr_r <= ptr_r + IDX_W'(1);
          end
        end
        T_IDLE: begin
          if (req.start) begin
            st_r   <= T_RUN;
            ptr_r  <= '0;
            id_r   <= req.id;
            hit_r  <= 1'b0;
            free_r <= 1'b0;
          end
        end
        T_RUN: begin
          if (ptr_r == LAST) begin
            st_r  <= T_IDLE;
            ptr_r <= '0;
          end else begin
            ptr_r <= ptr_r + IDX_W'(1);
          end
        end
        default: st_r <= T_IDLE;
      endcase
      // keep the first match and the first free slot
      if (rd_v_r) begin
        if (match && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= rd_idx_r;
          ent_r     <= rd_q;
        end
        if (is_free && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= rd_idx_r;
        end
      end
    end
  end

  assign ready       = (st_r == T_IDLE) && !rd_v_r && !done_r;
  assign res.done    = done_r;
  assign res.hit     = hit_r;
  assign res.free_ok = free_r;
  assign res.entry   = ent_r;
  assign hit_idx     = hit_idx_r;
  assign free_idx    = free_idx_r;

endmodule

/* rtl/core/akt_key_store.sv */
// ----------------------------------------------------------------------------
// akt_key_store
// Key word memory addressed by slot and word index; single port with a
// registered read. Words are qualified by the slot's word mask upstream.
// ----------------------------------------------------------------------------
module akt_key_store
  import akt_pkg::*;
#(
  parameter int NUM_SLOTS = 64,
  parameter int KA_W      = 8
) (
  input  logic            clk,
  input  logic            we,
  input  logic            re,
  input  logic [KA_W-1:0] addr,
  input  logic [63:0]     wdata,
  output logic [63:0]     rdata
);

  localparam int DEPTH = NUM_SLOTS * WMASK_W;

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_q;

  // One access per cycle: write or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rd_q <= mem[addr];
    end
  end

  assign rdata = rd_q;

endmodule
